// ===== rtl/core/lfrg_pkg.sv =====
`default_nettype none
package lfrg_pkg;

	localparam int MAX_COLS   = 256;
	localparam int MAX_ROWS   = 256;
	localparam int COL_W      = $clog2(MAX_COLS);
	localparam int ROW_W      = $clog2(MAX_ROWS);
	localparam int SIZE_W     = 9;
	localparam int HGT_W      = 9;
	localparam int AREA_W     = 17;
	localparam int DIST_W     = 16;
	localparam int WGT_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SDF_THR   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_AREA  = 2'd3;

	// stack entry: left edge of the span and the run height
	typedef struct packed {
		logic [COL_W-1:0] left;
		logic [HGT_W-1:0] hgt;
	} stk_ent_t;

	typedef struct packed {
		logic             we;
		logic [COL_W-1:0] waddr;
		stk_ent_t         wdata;
		logic             re;
		logic [COL_W-1:0] raddr;
	} stk_req_t;

	typedef struct packed {
		logic             re;
		logic             we;
		logic             clear;
		logic [COL_W-1:0] addr;
		logic [HGT_W-1:0] wdata;
	} col_req_t;

	typedef struct packed {
		logic mul;
		logic cmp;
		logic clr;
	} best_ctl_t;

	typedef struct packed {
		logic [AREA_W-1:0] area;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [HGT_W-1:0]  rows_high;
		logic [SIZE_W-1:0] cols_wide;
	} best_t;

endpackage
`default_nettype wire

// ===== rtl/core/lfrg_if.sv =====
`default_nettype none
interface lfrg_in_if;
	import lfrg_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     voxel_present;
	logic signed [DIST_W-1:0] sdf_distance;
	logic [WGT_W-1:0]         sdf_weight;
	modport source(output valid, voxel_present, sdf_distance, sdf_weight, input ready);
	modport sink(input valid, voxel_present, sdf_distance, sdf_weight, output ready);
endinterface

interface lfrg_out_if;
	import lfrg_pkg::*;
	logic              valid;
	logic              ready;
	logic              found;
	logic [AREA_W-1:0] best_area;
	logic [ROW_W-1:0]  best_row;
	logic [COL_W-1:0]  best_col;
	logic [HGT_W-1:0]  best_rows_high;
	logic [SIZE_W-1:0] best_cols_wide;
	modport source(output valid, found, best_area, best_row, best_col, best_rows_high,
		best_cols_wide, input ready);
	modport sink(input valid, found, best_area, best_row, best_col, best_rows_high,
		best_cols_wide, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/largest_free_rectangle_grid_core.sv =====
// Largest free rectangle over a streamed occupancy grid.
// in_ch takes one cell word per accepted valid/ready handshake, in row-major
// order; a cell is free when present, its distance exceeds the distance
// threshold and its weight is nonzero. After the last cell of a grid one
// result word is offered on out_ch (found, area, row, column, height, width);
// no word appears for other cells.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (0 grid_cols, 1 grid_rows, 2 distance threshold, 3 min_area_cells); write
// only while idle.
// Each cell updates its column height and then pops the stack; a row-end cell
// also flushes the columns left on the stack. Each column is pushed and popped
// once per row. Pops go one at a time through the shared area multiplier/
// compare unit and the stack memory.
// in_ch.ready is high only between cells.
// Reset clears the sizes to 256, the threshold and minimum area to zero,
// and all per-grid state; the column heights are cleared at once by valid
// bits, also at the end of every grid.
// The result sits in an output register; the next grid runs while it waits,
// and a grid end only stalls when the previous word was not yet taken.
`default_nettype none
module largest_free_rectangle_grid_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [lfrg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lfrg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	lfrg_in_if.sink                               in_ch,
	lfrg_out_if.source                            out_ch
);
	import lfrg_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HGT  = 3'd1;
	localparam logic [2:0] S_POP  = 3'd2;
	localparam logic [2:0] S_UPD  = 3'd3;
	localparam logic [2:0] S_RD   = 3'd4;
	localparam logic [2:0] S_END  = 3'd5;

	localparam logic [SIZE_W-1:0] COLS_MAX = SIZE_W'(MAX_COLS);
	localparam logic [SIZE_W-1:0] ROWS_MAX = SIZE_W'(MAX_ROWS);

	logic [SIZE_W-1:0]        grid_cols_q;
	logic [SIZE_W-1:0]        grid_rows_q;
	logic signed [DIST_W-1:0] sdf_thr_q;
	logic [AREA_W-1:0]        min_area_q;

	logic [2:0]        state_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SIZE_W-1:0] depth_q;
	logic [HGT_W-1:0]  hcur_q;
	logic [SIZE_W-1:0] pos_q;
	logic [COL_W-1:0]  lastleft_q;
	logic              free_q;
	logic              popped_q;
	logic              flush_q;
	logic              rowend_q;
	logic              gridend_q;

	logic              out_valid_q;
	best_t             out_q;
	logic              found_q;

	logic [SIZE_W-1:0] eff_cols;
	logic [SIZE_W-1:0] eff_rows;
	logic              acc;
	logic              cell_free;
	logic [HGT_W-1:0]  hnew;
	logic [HGT_W-1:0]  col_hgt;
	stk_ent_t          top;
	logic [SIZE_W-1:0] depth_dec;
	logic              do_pop;
	logic              load_out;
	col_req_t          col_req;
	stk_req_t          stk_req;
	best_ctl_t         best_ctl;
	best_t             best;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q <= COLS_MAX;
			grid_rows_q <= ROWS_MAX;
			sdf_thr_q   <= '0;
			min_area_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_COLS: grid_cols_q <= cfg_wdata[SIZE_W-1:0];
				REG_GRID_ROWS: grid_rows_q <= cfg_wdata[SIZE_W-1:0];
				REG_SDF_THR:   sdf_thr_q   <= cfg_wdata[DIST_W-1:0];
				REG_MIN_AREA:  min_area_q  <= cfg_wdata[AREA_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (grid_cols_q == '0) begin
			eff_cols = SIZE_W'(1);
		end else if (grid_cols_q > COLS_MAX) begin
			eff_cols = COLS_MAX;
		end else begin
			eff_cols = grid_cols_q;
		end
		if (grid_rows_q == '0) begin
			eff_rows = SIZE_W'(1);
		end else if (grid_rows_q > ROWS_MAX) begin
			eff_rows = ROWS_MAX;
		end else begin
			eff_rows = grid_rows_q;
		end
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign acc         = in_ch.valid && in_ch.ready;
	assign cell_free   = in_ch.voxel_present && (in_ch.sdf_distance > sdf_thr_q)
		&& (in_ch.sdf_weight != '0);
	assign hnew        = free_q ? col_hgt + HGT_W'(1) : '0;
	assign depth_dec   = depth_q - SIZE_W'(1);
	assign do_pop      = (depth_q != '0) && (flush_q || top.hgt >= hcur_q);
	assign load_out    = (state_q == S_END) && gridend_q && (!out_valid_q || out_ch.ready);

	always_comb begin
		col_req       = '0;
		col_req.addr  = col_q;
		col_req.wdata = hnew;
		col_req.re    = acc;
		col_req.we    = (state_q == S_HGT);
		col_req.clear = load_out;

		stk_req             = '0;
		stk_req.waddr       = depth_q[COL_W-1:0];
		stk_req.wdata.left  = popped_q ? lastleft_q : col_q;
		stk_req.wdata.hgt   = hcur_q;
		stk_req.raddr       = depth_dec[COL_W-1:0];
		unique case (state_q)
			S_IDLE: stk_req.re = acc;
			S_RD:   stk_req.re = 1'b1;
			S_POP: begin
				stk_req.re    = do_pop;
				stk_req.raddr = depth_dec[COL_W-1:0] - COL_W'(1);
				stk_req.we    = !do_pop && !flush_q;
			end
			default: ;
		endcase

		best_ctl     = '0;
		best_ctl.mul = (state_q == S_POP) && do_pop;
		best_ctl.cmp = (state_q == S_UPD);
		best_ctl.clr = load_out;
	end

	lfrg_col_store u_col_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (col_req),
		.rd_hgt (col_hgt)
	);

	lfrg_stack u_stack (
		.clk    (clk),
		.req    (stk_req),
		.rd_ent (top)
	);

	lfrg_best u_best (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (best_ctl),
		.hgt    (top.hgt),
		.wid    (pos_q - {1'b0, top.left}),
		.left   (top.left),
		.row    (row_q),
		.best   (best)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			col_q      <= '0;
			row_q      <= '0;
			depth_q    <= '0;
			hcur_q     <= '0;
			pos_q      <= '0;
			lastleft_q <= '0;
			free_q     <= 1'b0;
			popped_q   <= 1'b0;
			flush_q    <= 1'b0;
			rowend_q   <= 1'b0;
			gridend_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						free_q    <= cell_free;
						popped_q  <= 1'b0;
						flush_q   <= 1'b0;
						pos_q     <= {1'b0, col_q};
						rowend_q  <= ({1'b0, col_q} + SIZE_W'(1)) >= eff_cols;
						gridend_q <= ({1'b0, row_q} + SIZE_W'(1)) >= eff_rows;
						state_q   <= S_HGT;
					end
				end
				S_HGT: begin
					hcur_q  <= hnew;
					state_q <= S_POP;
				end
				S_POP: begin
					if (do_pop) begin
						depth_q    <= depth_dec;
						lastleft_q <= top.left;
						popped_q   <= 1'b1;
						state_q    <= S_UPD;
					end else if (!flush_q) begin
						depth_q <= depth_q + SIZE_W'(1);
						if (rowend_q) begin
							flush_q <= 1'b1;
							pos_q   <= {1'b0, col_q} + SIZE_W'(1);
							state_q <= S_RD;
						end else begin
							col_q   <= col_q + COL_W'(1);
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_END;
					end
				end
				S_UPD: state_q <= S_POP;
				S_RD:  state_q <= S_POP;
				S_END: begin
					col_q   <= '0;
					depth_q <= '0;
					if (!gridend_q) begin
						row_q   <= row_q + ROW_W'(1);
						state_q <= S_IDLE;
					end else if (load_out) begin
						row_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q   <= best;
			found_q <= best.area >= min_area_q;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.found          = found_q;
	assign out_ch.best_area      = out_q.area;
	assign out_ch.best_row       = out_q.row;
	assign out_ch.best_col       = out_q.col;
	assign out_ch.best_rows_high = out_q.rows_high;
	assign out_ch.best_cols_wide = out_q.cols_wide;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (depth_q <= {1'b0, col_q}))
		else $error("stack deeper than the columns scanned in this row");

	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (state_q == S_HGT))
		else $error("accepted cell did not start its height update");

	a_result_at_grid_end: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (depth_q == '0) && rowend_q)
		else $error("result loaded before the final row was flushed");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |=> out_valid_q && $stable(out_q))
		else $error("pending result word overwritten");

endmodule
`default_nettype wire

// ===== rtl/core/lfrg_col_store.sv =====
`default_nettype none
module lfrg_col_store (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire lfrg_pkg::col_req_t      req,
	output logic [lfrg_pkg::HGT_W-1:0]   rd_hgt
);
	import lfrg_pkg::*;

	logic [HGT_W-1:0]    mem [MAX_COLS];
	logic [MAX_COLS-1:0] valid_q;
	logic [HGT_W-1:0]    rd_data_q;
	logic                rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= mem[req.addr];
		end
	end

	// per-column valid bits give the zero heights of a fresh grid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.we) begin
				valid_q[req.addr] <= 1'b1;
			end
			if (req.re) begin
				rd_valid_q <= valid_q[req.addr];
			end
		end
	end

	assign rd_hgt = rd_valid_q ? rd_data_q : '0;

endmodule
`default_nettype wire

// ===== rtl/core/lfrg_stack.sv =====
`default_nettype none
module lfrg_stack (
	input  wire logic               clk,
	input  wire lfrg_pkg::stk_req_t req,
	output lfrg_pkg::stk_ent_t      rd_ent
);
	import lfrg_pkg::*;

	stk_ent_t mem [MAX_COLS];
	stk_ent_t rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= mem[req.raddr];
		end
	end

	assign rd_ent = rd_q;

endmodule
`default_nettype wire

// ===== rtl/core/lfrg_best.sv =====
`default_nettype none
module lfrg_best (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire lfrg_pkg::best_ctl_t      ctl,
	input  wire logic [lfrg_pkg::HGT_W-1:0]  hgt,
	input  wire logic [lfrg_pkg::SIZE_W-1:0] wid,
	input  wire logic [lfrg_pkg::COL_W-1:0]  left,
	input  wire logic [lfrg_pkg::ROW_W-1:0]  row,
	output lfrg_pkg::best_t               best
);
	import lfrg_pkg::*;

	logic [HGT_W+SIZE_W-1:0] prod;
	logic [AREA_W-1:0]       prod_q;
	logic [HGT_W-1:0]        hgt_q;
	logic [SIZE_W-1:0]       wid_q;
	logic [COL_W-1:0]        left_q;
	logic [HGT_W-1:0]        top_row;
	best_t                   best_q;

	assign prod    = hgt * wid;
	assign top_row = {1'b0, row} + HGT_W'(1) - hgt_q;

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_q <= prod[AREA_W-1:0];
			hgt_q  <= hgt;
			wid_q  <= wid;
			left_q <= left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (ctl.clr) begin
			best_q <= '0;
		end else if (ctl.cmp && prod_q > best_q.area) begin
			best_q.area      <= prod_q;
			best_q.rows_high <= hgt_q;
			best_q.cols_wide <= wid_q;
			best_q.col       <= left_q;
			best_q.row       <= top_row[ROW_W-1:0];
		end
	end

	assign best = best_q;

endmodule
`default_nettype wire
